/* rtl/tle_pkg.sv */
// Shared types and constants for the terminal line editor.
// No dependencies; imported by every module of the block.
`default_nettype none

package tle_pkg;

  localparam int unsigned LINE_BUFFER_MAX = 256;
  localparam int unsigned LIMIT_CAP_INT   = (LINE_BUFFER_MAX < 256) ? LINE_BUFFER_MAX : 256;
  localparam logic [8:0]  LIMIT_CAP       = 9'(LIMIT_CAP_INT);
  localparam logic [8:0]  BUF_SIZE_RESET  = 9'd256;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_TDATA_W = 16;

  typedef enum logic [1:0] {
    JOB_TERM,
    JOB_ERASE,
    JOB_STORE
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       conn;
    logic [7:0] chr;
    logic [7:0] idx;
    logic [7:0] len;
  } job_t;

endpackage

`default_nettype wire

/* rtl/tle_decode.sv */
// Byte classifier and line state (previous CR flag, character count).
// Depends on tle_pkg for character codes and the job type.
`default_nettype none

module tle_decode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic [7:0]      rx_byte,
  input  wire logic            host_connected,
  input  wire logic [8:0]      buffer_size,
  output logic                 job_valid,
  output tle_pkg::job_t        job
);
  import tle_pkg::*;

  logic       prev_was_cr_r, prev_was_cr_nxt;
  logic [7:0] char_count_r, char_count_nxt;
  logic [8:0] limit;
  logic       is_cr, is_lf, is_erase, is_print, room;

  always_comb begin
    is_cr    = (rx_byte == CH_CR);
    is_lf    = (rx_byte == CH_LF);
    is_erase = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
    is_print = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);
    limit    = (buffer_size < LIMIT_CAP) ? buffer_size : LIMIT_CAP;
    room     = ({1'b0, char_count_r} + 9'd1) < limit;

    job.conn = host_connected;
    job.chr  = rx_byte;
    job.idx  = char_count_r;
    job.len  = char_count_r;
    job.kind = JOB_STORE;
    job_valid = 1'b0;
    char_count_nxt  = char_count_r;
    prev_was_cr_nxt = is_cr;

    if (is_lf && prev_was_cr_r) begin
      job_valid = 1'b0;
    end else if (is_cr || is_lf) begin
      job.kind       = JOB_TERM;
      job_valid      = 1'b1;
      char_count_nxt = 8'd0;
    end else if (is_erase) begin
      job.kind = JOB_ERASE;
      if (char_count_r != 8'd0) begin
        job_valid      = 1'b1;
        char_count_nxt = char_count_r - 8'd1;
      end
    end else if (is_print && room) begin
      job.kind       = JOB_STORE;
      job_valid      = 1'b1;
      char_count_nxt = char_count_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_was_cr_r <= 1'b0;
      char_count_r  <= 8'd0;
    end else if (fire) begin
      prev_was_cr_r <= prev_was_cr_nxt;
      char_count_r  <= char_count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tle_emit.sv */
// Result register and step counter: plays out one to three echo results per job.
// Depends on tle_pkg for the job type and character codes.
`default_nettype none

module tle_emit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire tle_pkg::job_t                 job,
  output logic                               free,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [tle_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);
  import tle_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] step_r, step_nxt;
  job_t       job_r;
  logic       last;
  logic       echo_valid, store_valid, line_done;
  logic [7:0] echo_byte, store_index, store_char, line_length;

  always_comb begin
    echo_valid  = job_r.conn;
    echo_byte   = CH_BS;
    store_valid = 1'b0;
    store_index = 8'd0;
    store_char  = 8'd0;
    line_done   = 1'b0;
    line_length = 8'd0;
    last        = 1'b0;
    case (job_r.kind)
      JOB_TERM: begin
        echo_byte = (step_r == 2'd0) ? CH_CR : CH_LF;
        if (step_r != 2'd0) begin
          line_done   = 1'b1;
          line_length = job_r.len;
          last        = 1'b1;
        end
      end
      JOB_ERASE: begin
        echo_byte = (step_r == 2'd1) ? CH_SPACE : CH_BS;
        last      = (step_r == 2'd2);
      end
      JOB_STORE: begin
        echo_byte   = job_r.chr;
        store_valid = 1'b1;
        store_index = job_r.idx;
        store_char  = job_r.chr;
        last        = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase

    out_tvalid = valid_r;
    out_tlast  = last;
    out_tdata  = {5'd0, line_length, line_done, store_char, store_index, store_valid,
                  echo_byte, echo_valid};
    free       = !valid_r || (out_tready && last);

    valid_nxt = valid_r;
    step_nxt  = step_r;
    if (valid_r && out_tready) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 2'd1;
      end
    end
    if (load) begin
      valid_nxt = 1'b1;
      step_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
    end
  end

endmodule

`default_nettype wire

/* rtl/terminal_line_editor.sv */
// Terminal line editor top level: config register, byte decode and result play-out.
// Depends on tle_pkg, tle_decode and tle_emit.
//
// Usage:
//   in_*  : one received byte per request; tdata[7:0] rx_byte, tdata[8] host_connected.
//   out_* : echo/store/line results; tlast marks the final result of a byte.
//   cfg_* : writes buffer_size from cfg_tdata[8:0]; always ready.
// A byte is decoded in the cycle it is accepted and the line state advances
// then; its results appear from the next cycle, one per cycle while out_tready
// is high. A stored printable byte gives one result, a line end two (an LF
// right after a CR none), an erase of a stored character three, anything else
// none. A new byte is taken in the same cycle as the last result of the
// previous one leaves (one byte per cycle for printable text while out_tready
// is high). The single result register with its step counter sets that pace.
// When the receiver stalls the current result holds; in_tready
// stays low while results of a byte are pending, except in the cycle its last
// result is accepted. Reset clears the line length, the CR flag and any
// pending results, and sets buffer_size to 256.
`default_nettype none

module terminal_line_editor (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [7:0] rx_byte, [8] host_connected, [15:9] zero
  input  wire logic [tle_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [0] echo_valid, [8:1] echo_byte, [9] store_valid, [17:10] store_index,
  // [25:18] store_char, [26] line_done, [34:27] line_length, [39:35] zero
  output logic [tle_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                    out_tlast,
  input  wire logic                               cfg_tvalid,
  output logic                                    cfg_tready,
  // [8:0] buffer_size, [15:9] ignored
  input  wire logic [tle_pkg::CFG_TDATA_W-1:0]    cfg_tdata
);
  import tle_pkg::*;

  logic [8:0] buffer_size_r;
  logic       in_fire, job_valid, free;
  job_t       job;

  assign cfg_tready = 1'b1;
  assign in_tready  = free;
  assign in_fire    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= BUF_SIZE_RESET;
    end else if (cfg_tvalid && cfg_tready) begin
      buffer_size_r <= cfg_tdata[8:0];
    end
  end

  tle_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (in_fire),
    .rx_byte        (in_tdata[7:0]),
    .host_connected (in_tdata[8]),
    .buffer_size    (buffer_size_r),
    .job_valid      (job_valid),
    .job            (job)
  );

  tle_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire && job_valid),
    .job        (job),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |-> out_tlast)
    else $error("line_done on a result that is not the last");

  a_store_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tlast && !out_tdata[26])
    else $error("stored character result malformed");

  a_accept_frees: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tready && out_tlast)
    else $error("request accepted while results still pending");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

/* verif/tb.sv */
// Testbench for terminal_line_editor: directed and random received bytes, checked
// against an in-bench line editing predictor. Depends on tle_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
  import tle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic       echo_ok;
    logic [7:0] echo;
    logic       st_ok;
    logic [7:0] st_idx;
    logic [7:0] st_ch;
    logic       done;
    logic [7:0] len;
    logic       last;
  } line_event_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    cfg_tvalid = 1'b0;
  logic                    cfg_tready;
  logic [CFG_TDATA_W-1:0]  cfg_tdata = '0;

  line_event_t line_events[$];
  line_event_t want;
  logic [8:0]  buf_size;
  logic [7:0]  line_len;
  logic        prev_cr;
  bit          idle_on = 1'b1;
  int unsigned fail_count = 0;
  int unsigned cycles = 0;

  terminal_line_editor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= idle_on ? ($urandom_range(99) >= 17) : 1'b1;
  end

  task automatic add_event(input logic echo_ok, input logic [7:0] echo, input logic st_ok,
                           input logic [7:0] st_idx, input logic [7:0] st_ch,
                           input logic done, input logic [7:0] len, input logic last);
    line_events.push_back('{echo_ok, echo, st_ok, st_idx, st_ch, done, len, last});
  endtask

  task automatic edit_line(input logic [7:0] b, input logic conn);
    logic       was_cr;
    logic [8:0] room;
    was_cr  = prev_cr;
    prev_cr = (b == CH_CR);
    room    = (buf_size < LIMIT_CAP) ? buf_size : LIMIT_CAP;
    if (b == CH_LF && was_cr) begin
      return;
    end
    if (b == CH_CR || b == CH_LF) begin
      add_event(conn, CH_CR, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0);
      add_event(conn, CH_LF, 1'b0, 8'd0, 8'd0, 1'b1, line_len, 1'b1);
      line_len = 8'd0;
    end else if (b == CH_BS || b == CH_DEL) begin
      if (line_len != 8'd0) begin
        line_len = line_len - 8'd1;
        add_event(conn, CH_BS, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0);
        add_event(conn, CH_SPACE, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0);
        add_event(conn, CH_BS, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b1);
      end
    end else if (b >= CH_SPACE && b <= CH_TILDE) begin
      if ({1'b0, line_len} + 9'd1 < room) begin
        add_event(conn, b, 1'b1, line_len, b, 1'b0, 8'd0, 1'b1);
        line_len = line_len + 8'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (line_events.size() == 0) begin
        fail_count++;
        $error("result with nothing expected: tdata 0x%0h", out_tdata);
      end else begin
        want = line_events.pop_front();
        check_field("echo_valid", want.echo_ok, out_tdata[0]);
        check_field("echo_byte", want.echo, out_tdata[8:1]);
        check_field("store_valid", want.st_ok, out_tdata[9]);
        check_field("store_index", want.st_idx, out_tdata[17:10]);
        check_field("store_char", want.st_ch, out_tdata[25:18]);
        check_field("line_done", want.done, out_tdata[26]);
        check_field("line_length", want.len, out_tdata[34:27]);
        check_field("last_result", want.last, out_tlast);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic conn);
    int gap;
    if (idle_on && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, conn, b};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    edit_line(b, conn);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (line_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [8:0] v);
    settle();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {7'($urandom), v};
    do @(posedge clk); while (!(cfg_tvalid && cfg_tready));
    buf_size = v;
    cfg_tvalid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 8'($urandom_range(CH_SPACE, CH_TILDE));
    if (r < 66) return CH_BS;
    if (r < 71) return CH_DEL;
    if (r < 80) return CH_CR;
    if (r < 88) return CH_LF;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_directed();
    send_byte(8'h41, 1'b1);
    send_byte(CH_SPACE, 1'b1);
    send_byte(CH_TILDE, 1'b1);
    send_byte(8'h1F, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(CH_BS, 1'b1);
    send_byte(CH_DEL, 1'b1);
    send_byte(CH_BS, 1'b1);
    send_byte(CH_DEL, 1'b1);
    send_byte(CH_CR, 1'b1);
    send_byte(CH_LF, 1'b1);
    send_byte(CH_LF, 1'b1);
    send_byte(8'h78, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(8'h79, 1'b1);
    send_byte(8'h7A, 1'b0);
    send_byte(CH_BS, 1'b0);
    send_byte(CH_CR, 1'b1);
    send_byte(CH_CR, 1'b1);
    send_byte(CH_LF, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(CH_LF, 1'b1);
    settle();
  endtask

  task automatic test_room_limit();
    write_buffer_size(9'd1);
    send_byte(8'h61, 1'b1);
    send_byte(CH_BS, 1'b1);
    send_byte(CH_CR, 1'b1);
    write_buffer_size(9'd0);
    send_byte(8'h61, 1'b1);
    send_byte(CH_LF, 1'b1);
    write_buffer_size(9'd2);
    send_byte(8'h61, 1'b1);
    send_byte(8'h62, 1'b1);
    send_byte(CH_DEL, 1'b1);
    send_byte(8'h63, 1'b0);
    send_byte(CH_CR, 1'b1);
    write_buffer_size(9'd3);
    send_byte(8'h61, 1'b1);
    send_byte(8'h62, 1'b1);
    send_byte(8'h63, 1'b1);
    send_byte(CH_LF, 1'b1);
    settle();
  endtask

  task automatic test_long_line();
    write_buffer_size(9'h1FF);
    idle_on = 1'b0;
    repeat (256) send_byte(8'($urandom_range(CH_SPACE, CH_TILDE)), 1'($urandom_range(7) != 0));
    send_byte(CH_DEL, 1'b1);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h5A, 1'b1);
    send_byte(CH_CR, 1'b1);
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_text();
    logic [8:0] sizes [0:5];
    sizes[0] = 9'd256;
    sizes[1] = 9'd5;
    sizes[2] = 9'd1;
    sizes[3] = 9'd2;
    sizes[4] = 9'd40;
    sizes[5] = 9'($urandom_range(1, 256));
    for (int p = 0; p < 6; p++) begin
      write_buffer_size(sizes[p]);
      repeat (2) send_byte(pick_byte(), 1'($urandom_range(9) != 0));
    end
    settle();
  endtask

  initial begin
    buf_size = BUF_SIZE_RESET;
    line_len = 8'd0;
    prev_cr  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_room_limit();
    test_long_line();
    test_random_text();
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
